[hw/rtl/iniskv_pkg.sv]
package iniskv_pkg;

   localparam logic [7:0] CH_OPEN   = 8'h5B;
   localparam logic [7:0] CH_CLOSE  = 8'h5D;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;

   localparam int CHAR_W     = 8;
   localparam int VLEN_W     = 5;
   localparam int NAME_CHARS = 16;
   localparam int NAME_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int HIGH_W     = 56;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SECTION_LOW  = 3'd0,
      REG_SECTION_HIGH = 3'd1,
      REG_SECTION_LEN  = 3'd2,
      REG_KEY_LOW      = 3'd3,
      REG_KEY_HIGH     = 3'd4,
      REG_KEY_LEN      = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      MODE_SEEK,
      MODE_SECTION,
      MODE_KEY,
      MODE_VALUE,
      MODE_OUR_VALUE
   } mode_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_SHOW
   } back_state_type;

   typedef logic [NAME_CHARS-1:0][CHAR_W-1:0] name_type;

   // Unpack a 15-character target (low/high register pair); character 15 reads as NUL.
   function automatic name_type unpack_name(input logic [CSR_DATA_W-1:0] lo,
                                            input logic [HIGH_W-1:0]     hi);
      name_type n;
      n = {8'h00, hi, lo};
      return n;
   endfunction

   // Effective target length: first NUL below the length register, else the length.
   function automatic logic [NAME_W-1:0] target_length(input name_type n,
                                                       input logic [NAME_W-1:0] len);
      logic [NAME_W-1:0] tl;
      tl = len;
      for (int i = NAME_CHARS - 2; i >= 0; i--) begin
         if ((NAME_W'(i) < len) && (n[i] == 8'h00)) begin
            tl = NAME_W'(i);
         end
      end
      return tl;
   endfunction

endpackage

[hw/rtl/iniskv_fifo.sv]
module iniskv_fifo #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && (count_ff != CNT_W'(DEPTH));
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/iniskv_front.sv]
module iniskv_front #(
   parameter int SECTION_CAPACITY = 16,
   parameter int KEY_CAPACITY     = 16,
   parameter int VALUE_CAPACITY   = 32,
   parameter int FILL_W           = 7,
   parameter int LEN_W            = 5
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [iniskv_pkg::CHAR_W-1:0]        req_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [iniskv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [iniskv_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                                 backlog,
   output logic                                 mem_wr_en,
   output logic [LEN_W-1:0]                     mem_wr_addr,
   output logic [iniskv_pkg::CHAR_W-1:0]        mem_wr_data,
   output logic                                 len_push,
   output logic [LEN_W-1:0]                     len_data
);
   import iniskv_pkg::*;

   logic [CSR_DATA_W-1:0] sec_lo_ff, key_lo_ff;
   logic [HIGH_W-1:0]     sec_hi_ff, key_hi_ff;
   logic [NAME_W-1:0]     sec_len_ff, key_len_ff;

   mode_type              mode_ff, mode_in;
   logic [FILL_W-1:0]     fill_ff, fill_in, fill_inc;
   // running compare of the name being captured against its target
   logic [NAME_W-1:0]     alen_ff, alen_in;
   logic                  nul_ff, nul_in, mis_ff, mis_in;

   name_type              sec_name, key_name, tgt_name;
   logic [NAME_W-1:0]     sec_tl, key_tl, tgt_tl;
   logic                  accept, line_end, name_hit, value_mode;
   logic [CHAR_W-1:0]     b;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_lo_ff  <= '0;
         sec_hi_ff  <= '0;
         sec_len_ff <= '0;
         key_lo_ff  <= '0;
         key_hi_ff  <= '0;
         key_len_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SECTION_LOW:  sec_lo_ff  <= csr_data;
            REG_SECTION_HIGH: sec_hi_ff  <= csr_data[HIGH_W-1:0];
            REG_SECTION_LEN:  sec_len_ff <= csr_data[NAME_W-1:0];
            REG_KEY_LOW:      key_lo_ff  <= csr_data;
            REG_KEY_HIGH:     key_hi_ff  <= csr_data[HIGH_W-1:0];
            REG_KEY_LEN:      key_len_ff <= csr_data[NAME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign sec_name = unpack_name(sec_lo_ff, sec_hi_ff);
   assign key_name = unpack_name(key_lo_ff, key_hi_ff);
   assign sec_tl   = target_length(sec_name, sec_len_ff);
   assign key_tl   = target_length(key_name, key_len_ff);
   assign tgt_name = (mode_ff == MODE_KEY) ? key_name : sec_name;
   assign tgt_tl   = (mode_ff == MODE_KEY) ? key_tl : sec_tl;

   // value bytes share one buffer with the replay; hold off while a burst is pending
   assign value_mode = (mode_ff == MODE_VALUE) || (mode_ff == MODE_OUR_VALUE);
   assign req_tready = !(value_mode && backlog);
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign line_end   = (b == CH_LF) || (b == CH_CR);
   assign fill_inc   = fill_ff + 1'b1;
   assign name_hit   = !mis_ff && (alen_ff == tgt_tl);

   always_comb begin
      mode_in     = mode_ff;
      fill_in     = fill_ff;
      alen_in     = alen_ff;
      nul_in      = nul_ff;
      mis_in      = mis_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = fill_ff[LEN_W-1:0];
      mem_wr_data = b;
      len_push    = 1'b0;
      len_data    = fill_ff[LEN_W-1:0];
      if (accept) begin
         case (mode_ff)
            MODE_SEEK: begin
               if (b == CH_OPEN) begin
                  fill_in = '0;
                  alen_in = '0;
                  nul_in  = 1'b0;
                  mis_in  = 1'b0;
                  mode_in = MODE_SECTION;
               end
            end
            MODE_SECTION, MODE_KEY: begin
               if (mode_ff == MODE_SECTION && b == CH_CLOSE) begin
                  fill_in = '0;
                  alen_in = '0;
                  nul_in  = 1'b0;
                  mis_in  = 1'b0;
                  mode_in = name_hit ? MODE_KEY : MODE_SEEK;
               end else if (mode_ff == MODE_KEY && b == CH_EQUALS) begin
                  fill_in = '0;
                  mode_in = name_hit ? MODE_OUR_VALUE : MODE_VALUE;
               end else if (mode_ff == MODE_KEY && line_end) begin
                  mode_in = mode_ff;
               end else if (mode_ff == MODE_KEY && b == CH_OPEN) begin
                  fill_in = '0;
                  alen_in = '0;
                  nul_in  = 1'b0;
                  mis_in  = 1'b0;
                  mode_in = MODE_SECTION;
               end else begin
                  // strcmp semantics: bytes after a NUL are ignored
                  if (!nul_ff) begin
                     if (b == 8'h00) begin
                        nul_in = 1'b1;
                     end else begin
                        alen_in = alen_ff + 1'b1;
                        if (alen_ff >= tgt_tl || b != tgt_name[alen_ff]) begin
                           mis_in = 1'b1;
                        end
                     end
                  end
                  fill_in = fill_inc;
                  if (mode_ff == MODE_SECTION) begin
                     if (fill_inc >= FILL_W'(SECTION_CAPACITY)) begin
                        mode_in = MODE_SEEK;
                     end
                  end else if (fill_inc >= FILL_W'(KEY_CAPACITY)) begin
                     mode_in = MODE_SEEK;
                  end
               end
            end
            MODE_VALUE, MODE_OUR_VALUE: begin
               if (!line_end) begin
                  mem_wr_en = 1'b1;
                  fill_in   = fill_inc;
                  if (fill_inc >= FILL_W'(VALUE_CAPACITY)) begin
                     mode_in = MODE_SEEK;
                  end
               end else if (mode_ff == MODE_VALUE) begin
                  fill_in = '0;
                  alen_in = '0;
                  nul_in  = 1'b0;
                  mis_in  = 1'b0;
                  mode_in = MODE_KEY;
               end else begin
                  len_push = 1'b1;
                  mode_in  = MODE_SEEK;
               end
            end
            default: mode_in = MODE_SEEK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SEEK;
         fill_ff <= '0;
         alen_ff <= '0;
         nul_ff  <= 1'b0;
         mis_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         fill_ff <= fill_in;
         alen_ff <= alen_in;
         nul_ff  <= nul_in;
         mis_ff  <= mis_in;
      end
   end

endmodule

[hw/rtl/iniskv_back.sv]
module iniskv_back #(
   parameter int VALUE_CAPACITY = 32,
   parameter int LEN_W          = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              mem_wr_en,
   input  logic [LEN_W-1:0]                  mem_wr_addr,
   input  logic [iniskv_pkg::CHAR_W-1:0]     mem_wr_data,
   input  logic                              len_empty,
   input  logic [LEN_W-1:0]                  len_data,
   output logic                              len_pop,
   output logic                              busy,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,  // [7:0] value_char, [12:8] value_length
   output logic                              rsp_tlast   // last_of_value
);
   import iniskv_pkg::*;

   logic [CHAR_W-1:0]    value_mem [VALUE_CAPACITY];
   logic [CHAR_W-1:0]    rd_data_ff;

   back_state_type       state_ff, state_in;
   logic [LEN_W-1:0]     len_ff, len_in, k_ff, k_in, k_inc;
   logic                 zero_ff, zero_in;
   logic                 last;
   logic [VLEN_W-1:0]    vlen;

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         value_mem[mem_wr_addr] <= mem_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BK_READ) begin
         rd_data_ff <= value_mem[k_ff];
      end
   end

   assign k_inc     = k_ff + 1'b1;
   assign last      = zero_ff || (k_inc == len_ff);
   assign vlen      = VLEN_W'(len_ff);
   assign busy      = (state_ff != BK_IDLE);
   assign rsp_tdata = {3'b000, vlen, zero_ff ? 8'h00 : rd_data_ff};
   assign rsp_tlast = last;

   always_comb begin
      state_in   = state_ff;
      len_in     = len_ff;
      k_in       = k_ff;
      zero_in    = zero_ff;
      len_pop    = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!len_empty) begin
               len_pop = 1'b1;
               len_in  = len_data;
               k_in    = '0;
               zero_in = (len_data == '0);
               state_in = (len_data == '0) ? BK_SHOW : BK_READ;
            end
         end
         BK_READ: state_in = BK_SHOW;
         BK_SHOW: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               if (last) begin
                  state_in = BK_IDLE;
               end else begin
                  k_in     = k_inc;
                  state_in = BK_READ;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         len_ff   <= '0;
         k_ff     <= '0;
         zero_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         k_ff     <= k_in;
         zero_ff  <= zero_in;
      end
   end

endmodule

[hw/rtl/ini_section_key_value_extractor.sv]
// Channel   Direction  Ports                               Payload
// req       in         req_tvalid/req_tready/req_tdata     text_byte
// rsp       out        rsp_tvalid/rsp_tready/rsp_tdata     value_char, value_length; tlast
// csr       in         csr_valid/csr_ready/csr_index/data  register write, always ready
//
// The parser takes one text byte per cycle while it is not held off. Value bytes
// share a buffer with the replay unit, so they wait while a found value is still
// queued or replaying. Replay reads each value byte from the buffer into the output
// register before it is shown; an empty value gives one result with no buffer read.
// Reset is synchronous and clears the parser, queue and replay control.
module ini_section_key_value_extractor #(
   parameter int SECTION_CAPACITY = 16,
   parameter int KEY_CAPACITY     = 16,
   parameter int VALUE_CAPACITY   = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // [7:0] text_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,  // [7:0] value_char, [12:8] value_length
   output logic                              rsp_tlast,  // last_of_value
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [iniskv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [iniskv_pkg::CSR_DATA_W-1:0] csr_data
);
   import iniskv_pkg::*;

   localparam int MAX_SK  = (SECTION_CAPACITY > KEY_CAPACITY) ? SECTION_CAPACITY
                                                              : KEY_CAPACITY;
   localparam int MAX_CAP = (MAX_SK > VALUE_CAPACITY) ? MAX_SK : VALUE_CAPACITY;
   localparam int FILL_W  = $clog2(MAX_CAP + 1);
   localparam int LEN_W   = $clog2(VALUE_CAPACITY);

   logic              mem_wr_en, len_push, len_pop, len_empty, back_busy, backlog;
   logic [LEN_W-1:0]  mem_wr_addr, push_len, pop_len;
   logic [CHAR_W-1:0] mem_wr_data;

   assign backlog = !len_empty || back_busy;

   iniskv_front #(
      .SECTION_CAPACITY (SECTION_CAPACITY),
      .KEY_CAPACITY     (KEY_CAPACITY),
      .VALUE_CAPACITY   (VALUE_CAPACITY),
      .FILL_W           (FILL_W),
      .LEN_W            (LEN_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .backlog     (backlog),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .len_push    (len_push),
      .len_data    (push_len)
   );

   iniskv_fifo #(
      .WIDTH (LEN_W),
      .DEPTH (2)
   ) u_len_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (len_push),
      .push_data (push_len),
      .pop       (len_pop),
      .pop_data  (pop_len),
      .empty     (len_empty)
   );

   iniskv_back #(
      .VALUE_CAPACITY (VALUE_CAPACITY),
      .LEN_W          (LEN_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .len_empty   (len_empty),
      .len_data    (pop_len),
      .len_pop     (len_pop),
      .busy        (back_busy),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

[sim/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import iniskv_pkg::*;

   localparam int HALF_PERIOD  = 2;
   localparam int SECT_CAP     = 16;
   localparam int KEY_CAP      = 16;
   localparam int VAL_CAP      = 32;
   localparam int DRAIN_CYCLES = 70;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 2000;

   typedef struct packed {
      logic [7:0] ch;
      logic [4:0] len;
      logic       last;
   } value_beat_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [15:0]           rsp_tdata;   // [7:0] value_char, [12:8] value_length
   logic                  rsp_tlast;   // last_of_value
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   // parser shadow and target registers
   mode_type    scan_mode = MODE_SEEK;
   int          scan_fill = 0;
   logic [7:0]  sect_chars [SECT_CAP];
   logic [7:0]  key_chars  [KEY_CAP];
   logic [7:0]  val_chars  [VAL_CAP];
   logic [63:0] sect_lo  = '0;
   logic [55:0] sect_hi  = '0;
   logic [3:0]  sect_len = '0;
   logic [63:0] key_lo   = '0;
   logic [55:0] key_hi   = '0;
   logic [3:0]  key_len  = '0;

   value_beat_type value_queue [$];
   int          errors          = 0;
   int          text_sent       = 0;
   int          beats_predicted = 0;
   int          beats_checked   = 0;
   int          tx_idle_pct     = 0;
   int          rx_idle_pct     = 0;
   bit          hold_request    = 0;
   int          hold_left       = 0;
   int          stall_cycles    = 0;

   ini_section_key_value_extractor #(
      .SECTION_CAPACITY(SECT_CAP),
      .KEY_CAPACITY    (KEY_CAP),
      .VALUE_CAPACITY  (VAL_CAP)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // strcmp-style compare: captured name stops at NUL or fill count,
   // target stops at NUL or its length register
   function automatic bit name_hits(input logic [7:0] chars [16], input int count,
                                    input logic [63:0] lo, input logic [55:0] hi,
                                    input logic [3:0] len);
      logic [119:0] tgt;
      int a;
      int b;
      tgt = {hi, lo};
      a = 0;
      b = 0;
      if (count > 16) count = 16;
      while (a < count && chars[a] != 8'h00) a++;
      while (b < int'(len) && b < 15 && tgt[8*b +: 8] != 8'h00) b++;
      if (a != b) return 1'b0;
      for (int i = 0; i < a; i++) begin
         if (chars[i] != tgt[8*i +: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic push_beat(input logic [7:0] ch, input int len, input logic last);
      value_beat_type beat;
      beat.ch   = ch;
      beat.len  = 5'(len);
      beat.last = last;
      value_queue.push_back(beat);
      beats_predicted++;
   endtask

   task automatic predict_byte(input logic [7:0] b);
      case (scan_mode)
         MODE_SEEK: begin
            if (b == CH_OPEN) begin
               scan_fill = 0;
               scan_mode = MODE_SECTION;
            end
         end
         MODE_SECTION: begin
            if (b != CH_CLOSE) begin
               if (scan_fill < SECT_CAP) sect_chars[scan_fill] = b;
               scan_fill++;
               if (scan_fill >= SECT_CAP) scan_mode = MODE_SEEK;
            end else if (name_hits(sect_chars, scan_fill, sect_lo, sect_hi, sect_len)) begin
               scan_fill = 0;
               scan_mode = MODE_KEY;
            end else begin
               scan_mode = MODE_SEEK;
            end
         end
         MODE_KEY: begin
            if (b == CH_EQUALS) begin
               scan_mode = name_hits(key_chars, scan_fill, key_lo, key_hi, key_len) ?
                           MODE_OUR_VALUE : MODE_VALUE;
               scan_fill = 0;
            end else if (b != CH_LF && b != CH_CR) begin
               if (b == CH_OPEN) begin
                  scan_fill = 0;
                  scan_mode = MODE_SECTION;
               end else begin
                  if (scan_fill < KEY_CAP) key_chars[scan_fill] = b;
                  scan_fill++;
                  if (scan_fill >= KEY_CAP) scan_mode = MODE_SEEK;
               end
            end
         end
         MODE_VALUE, MODE_OUR_VALUE: begin
            if (b != CH_LF && b != CH_CR) begin
               if (scan_fill < VAL_CAP) val_chars[scan_fill] = b;
               scan_fill++;
               if (scan_fill >= VAL_CAP) scan_mode = MODE_SEEK;
            end else if (scan_mode == MODE_VALUE) begin
               scan_fill = 0;
               scan_mode = MODE_KEY;
            end else begin
               if (scan_fill == 0) begin
                  push_beat(8'h00, 0, 1'b1);
               end else begin
                  for (int k = 0; k < scan_fill; k++)
                     push_beat(val_chars[k], scan_fill, k + 1 == scan_fill);
               end
               scan_mode = MODE_SEEK;
            end
         end
         default: scan_mode = MODE_SEEK;
      endcase
   endtask

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      text_sent++;
      predict_byte(b);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // stop offering text, let every expected result arrive, then let replay settle
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (value_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_reg_type idx, input logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SECTION_LOW:  sect_lo  = data;
         REG_SECTION_HIGH: sect_hi  = data[55:0];
         REG_SECTION_LEN:  sect_len = data[3:0];
         REG_KEY_LOW:      key_lo   = data;
         REG_KEY_HIGH:     key_hi   = data[55:0];
         REG_KEY_LEN:      key_len  = data[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_targets(input logic [63:0] s_lo, input logic [55:0] s_hi,
                                  input logic [63:0] s_len, input logic [63:0] k_lo,
                                  input logic [55:0] k_hi, input logic [63:0] k_len);
      wait_idle();
      write_csr(REG_SECTION_LOW, s_lo);
      write_csr(REG_SECTION_HIGH, {8'h00, s_hi});
      write_csr(REG_SECTION_LEN, s_len);
      write_csr(REG_KEY_LOW, k_lo);
      write_csr(REG_KEY_HIGH, {8'h00, k_hi});
      write_csr(REG_KEY_LEN, k_len);
   endtask

   function automatic logic [119:0] pack_name(input string s);
      logic [119:0] v;
      v = '0;
      for (int i = 0; i < s.len() && i < 15; i++) v[8*i +: 8] = s[i];
      return v;
   endfunction

   task automatic program_names(input string sec, input string key);
      logic [119:0] sv;
      logic [119:0] kv;
      sv = pack_name(sec);
      kv = pack_name(key);
      program_targets(sv[63:0], sv[119:64], 64'(sec.len()),
                      kv[63:0], kv[119:64], 64'(key.len()));
   endtask

   function automatic logic [7:0] random_value_byte();
      logic [7:0] v;
      do v = 8'($urandom_range(255)); while (v == CH_LF || v == CH_CR);
      return v;
   endfunction

   // ---------------- tests ----------------

   task automatic test_basic_lookup();
      program_names("s", "k");
      send_text("[s]\nk=v\n");
      send_text("[s]k=\r");           // empty value
      send_text("]x[t]k=9\n");        // stray close, wrong section
   endtask

   task automatic test_line_ends_and_restart();
      send_text("[s]x=1\r\nk=ab\r");
      send_text("[s]q[s]k=z\n");      // open bracket among key bytes
   endtask

   task automatic test_name_truncation();
      // target "s", NUL, "y" and target key "k" with junk past its length
      program_targets(64'h0000_0000_0079_0073, 56'hAB_CDEF_0123_4567, 64'd3,
                      64'hFFFF_FFFF_FFFF_FF6B, '0, 64'd1);
      send_text("[s");
      send_byte(8'h00);
      send_text("q]k=n\n");
   endtask

   task automatic test_overflow();
      program_names("s", "k");
      send_byte(CH_OPEN);
      repeat (SECT_CAP) send_byte("a");
      send_text("[s]");
      repeat (KEY_CAP) send_byte("b");
   endtask

   task automatic test_name_extremes();
      program_targets({64{1'b1}}, {56{1'b1}}, 64'd15, {64{1'b1}}, {56{1'b1}}, 64'd15);
      send_byte(CH_OPEN);
      repeat (15) send_byte(8'hFF);
      send_byte(CH_CLOSE);
      repeat (15) send_byte(8'hFF);
      send_byte(CH_EQUALS);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(CH_LF);
      program_targets('0, '0, '0, '0, '0, '0);
      send_text("[]=\n");
   endtask

   // longest value replayed under a long output hold, then a value that
   // overflows its buffer while the input is stalled behind the replay
   task automatic test_backpressure();
      program_names("s", "k");
      hold_request = 1'b1;
      send_text("[s]k=");
      repeat (VAL_CAP - 1) send_byte(random_value_byte());
      send_byte(CH_CR);
      send_text("[s]k=");
      repeat (VAL_CAP) send_byte(random_value_byte());
   endtask

   // ---------------- receiver, checker, watchdog ----------------

   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      value_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_checked++;
         if (value_queue.size() == 0) begin
            $display("%0t: unexpected result, data %h tlast %b", $time, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = value_queue.pop_front();
            if (rsp_tdata[7:0] != want.ch) begin
               $display("%0t: value_char expected %02h actual %02h",
                        $time, want.ch, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tdata[12:8] != want.len) begin
               $display("%0t: value_length expected %0d actual %0d",
                        $time, want.len, rsp_tdata[12:8]);
               errors++;
            end
            if (rsp_tlast != want.last) begin
               $display("%0t: last_of_value expected %b actual %b",
                        $time, want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, STALL_LIMIT, value_queue.size());
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 17;
      rx_idle_pct = 88;
      test_basic_lookup();
      test_name_truncation();
      test_overflow();

      tx_idle_pct = 88;
      rx_idle_pct = 17;
      test_line_ends_and_restart();
      test_name_extremes();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_backpressure();

      wait_idle();
      $display("Sent %0d text bytes and checked %0d value results: directed lookups,",
               text_sent, beats_checked);
      $display("line ends, overflow, NUL truncation, full-length names, longest value held.");
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/iniskv_pkg.sv
hw/rtl/iniskv_fifo.sv
hw/rtl/iniskv_front.sv
hw/rtl/iniskv_back.sv
hw/rtl/ini_section_key_value_extractor.sv
sim/tb_top.sv
